// File: rtl/core/cab_pkg.sv
// shared types, constants and register codes for the clipped alpha blit
`timescale 1ns / 1ps

package cab_pkg;

  localparam int PIX_W       = 32;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 3;
  localparam int MAX_DIM_DEF = 4096;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PLACE_COL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLACE_ROW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLEND_MODE = 3'd6;

  // blend modes, the unused code acts as blend
  localparam logic [MODE_W-1:0] MODE_COPY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLEND = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] upper_pixel;
    logic [PIX_W-1:0] lower_pixel;
  } cab_in_t;

  typedef struct packed {
    logic               write_enable;
    logic [COORD_W-1:0] target_col;
    logic [COORD_W-1:0] target_row;
    logic [PIX_W-1:0]   result_pixel;
    logic               last;
  } cab_out_t;

  // saturated configuration as seen by the datapath
  typedef struct packed {
    logic signed [DIM_W-1:0] place_col;
    logic signed [DIM_W-1:0] place_row;
    logic [DIM_W-1:0]        src_width;
    logic [DIM_W-1:0]        src_height;
    logic [DIM_W-1:0]        dst_width;
    logic [DIM_W-1:0]        dst_height;
    logic [MODE_W-1:0]       blend_mode;
  } cab_cfg_t;

  // item after placement and clipping, ahead of compositing
  typedef struct packed {
    logic               in_bounds;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic [PIX_W-1:0]   upper_pixel;
    logic [PIX_W-1:0]   lower_pixel;
  } cab_stage_t;

endpackage

// File: rtl/core/cab_cfg_regs.sv
// configuration registers with size saturation
`timescale 1ns / 1ps

module cab_cfg_regs #(
  parameter int MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [cab_pkg::IDX_W-1:0]  cfg_index,
  input  logic [cab_pkg::DIM_W-1:0]  cfg_data,
  output cab_pkg::cab_cfg_t          cfg
);

  localparam int CMP_W = cab_pkg::DIM_W + 5;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DIM);
  localparam logic [cab_pkg::DIM_W-1:0] MAX_SAT = cab_pkg::DIM_W'(MAX_DIM);

  logic [cab_pkg::DIM_W-1:0]  place_col_r, place_row_r;
  logic [cab_pkg::DIM_W-1:0]  src_width_r, src_height_r;
  logic [cab_pkg::DIM_W-1:0]  dst_width_r, dst_height_r;
  logic [cab_pkg::MODE_W-1:0] blend_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_col_r  <= '0;
      place_row_r  <= '0;
      src_width_r  <= '0;
      src_height_r <= '0;
      dst_width_r  <= '0;
      dst_height_r <= '0;
      blend_mode_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cab_pkg::REG_PLACE_COL:  place_col_r  <= cfg_data;
        cab_pkg::REG_PLACE_ROW:  place_row_r  <= cfg_data;
        cab_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        cab_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        cab_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_data;
        cab_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_data;
        cab_pkg::REG_BLEND_MODE: blend_mode_r <= cfg_data[cab_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [cab_pkg::DIM_W-1:0] sat_dim(input logic [cab_pkg::DIM_W-1:0] v);
    sat_dim = ({5'd0, v} > MAX_CMP) ? MAX_SAT : v;
  endfunction

  always_comb begin
    cfg.place_col  = signed'(place_col_r);
    cfg.place_row  = signed'(place_row_r);
    cfg.src_width  = sat_dim(src_width_r);
    cfg.src_height = sat_dim(src_height_r);
    cfg.dst_width  = sat_dim(dst_width_r);
    cfg.dst_height = sat_dim(dst_height_r);
    cfg.blend_mode = blend_mode_r;
  end

endmodule

// File: rtl/core/cab_walker.sv
// raster counters, placement and clipping, registered input stage
`timescale 1ns / 1ps

module cab_walker #(
  parameter int MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cab_pkg::cab_in_t    in_data,
  input  cab_pkg::cab_cfg_t   cfg,
  output logic                st_valid,
  input  logic                st_ready,
  output cab_pkg::cab_stage_t st_data
);

  localparam int DW     = cab_pkg::DIM_W;
  localparam int CNT_LIM = (MAX_DIM < (1 << DW)) ? MAX_DIM : (1 << DW);
  localparam int CNT_W  = $clog2(CNT_LIM);
  localparam int POS_W  = DW + 2;

  logic [CNT_W-1:0]         col_r, col_nxt;
  logic [CNT_W-1:0]         row_r, row_nxt;
  logic                     st_valid_r;
  cab_pkg::cab_stage_t      st_r, st_nxt;
  logic                     accept;
  logic                     empty;
  logic                     row_end, img_end;
  logic signed [POS_W-1:0]  tx, ty;

  assign in_ready = !st_valid_r || st_ready;
  assign accept   = in_valid && in_ready;
  assign st_valid = st_valid_r;
  assign st_data  = st_r;

  always_comb begin
    empty   = (cfg.src_width == '0) || (cfg.src_height == '0);
    tx      = POS_W'(cfg.place_col) + signed'(POS_W'(col_r));
    ty      = POS_W'(cfg.place_row) + signed'(POS_W'(row_r));
    row_end = ((DW + 1)'(col_r) + 1'b1) >= (DW + 1)'(cfg.src_width);
    img_end = ((DW + 1)'(row_r) + 1'b1) >= (DW + 1)'(cfg.src_height);

    st_nxt.in_bounds = !empty && !tx[POS_W-1] && !ty[POS_W-1]
                       && (tx[POS_W-2:0] < (POS_W - 1)'(cfg.dst_width))
                       && (ty[POS_W-2:0] < (POS_W - 1)'(cfg.dst_height));
    st_nxt.col         = tx[cab_pkg::COORD_W-1:0];
    st_nxt.row         = ty[cab_pkg::COORD_W-1:0];
    st_nxt.last        = !empty && row_end && img_end;
    st_nxt.upper_pixel = in_data.upper_pixel;
    st_nxt.lower_pixel = in_data.lower_pixel;

    if (empty) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = img_end ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      st_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_ready) begin
        st_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/core/cab_compose.sv
// per pixel compositing: copy, keyed copy or per channel alpha blend
`timescale 1ns / 1ps

module cab_compose (
  input  cab_pkg::cab_stage_t         st,
  input  logic [cab_pkg::MODE_W-1:0]  mode,
  output cab_pkg::cab_out_t           res
);

  localparam int CH_N = cab_pkg::PIX_W / 8;

  logic [7:0]             alpha;
  logic [7:0]             inv_alpha;
  logic [15:0]            mix   [CH_N];
  logic [15:0]            quot  [CH_N];
  logic [cab_pkg::PIX_W-1:0] blended;
  logic                   we;
  logic [cab_pkg::PIX_W-1:0] pix;

  assign alpha     = st.upper_pixel[cab_pkg::PIX_W-1 -: 8];
  assign inv_alpha = 8'd255 - alpha;

  // x / 255 as (x + (x >> 8) + 1) >> 8, exact below 65535
  always_comb begin
    for (int i = 0; i < CH_N; i++) begin
      mix[i]  = ({8'd0, st.upper_pixel[i*8 +: 8]} * {8'd0, alpha})
              + ({8'd0, st.lower_pixel[i*8 +: 8]} * {8'd0, inv_alpha}) + 16'd254;
      quot[i] = mix[i] + {8'd0, mix[i][15:8]} + 16'd1;
      blended[i*8 +: 8] = quot[i][15:8];
    end
  end

  always_comb begin
    we  = 1'b0;
    pix = '0;
    if (st.in_bounds) begin
      case (mode)
        cab_pkg::MODE_COPY: begin
          we  = 1'b1;
          pix = st.upper_pixel;
        end
        cab_pkg::MODE_KEY: begin
          we  = st.upper_pixel[cab_pkg::PIX_W-1];
          pix = we ? st.upper_pixel : st.lower_pixel;
        end
        default: begin
          we = 1'b1;
          if (alpha == 8'd255) begin
            pix = st.upper_pixel;
          end else if (alpha == 8'd0) begin
            pix = st.lower_pixel;
          end else begin
            pix = blended;
          end
        end
      endcase
    end
    res.write_enable = we;
    res.target_col   = we ? st.col : '0;
    res.target_row   = we ? st.row : '0;
    res.result_pixel = pix;
    res.last         = st.last;
  end

endmodule

// File: rtl/core/clipped_alpha_blit.sv
// top level of the clipped alpha blit: config, placement stage, compositing, result register
//
//   channel  ports                          direction  moves
//   in       in_valid in_ready in_data      input      source and target pixel item
//   out      out_valid out_ready out_data   output     write flag, coordinates, pixel, last
//   cfg      cfg_valid cfg_ready cfg_index  input      register index and write data
//            cfg_data
//
// the placement register and then the result register lie between input accept and result valid;
// one item per cycle sustained while out_ready holds high; the rate is set by the placement
// register and the result register, the blend multipliers sit between them.
// synchronous active low reset clears counters, configuration registers and valid flags.
// a stalled result holds the result register; the placement stage still
// takes one more item behind it; cfg_ready is always high.
`timescale 1ns / 1ps

module clipped_alpha_blit #(
  parameter int MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cab_pkg::cab_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cab_pkg::cab_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cab_pkg::IDX_W-1:0]  cfg_index,
  input  logic [cab_pkg::DIM_W-1:0]  cfg_data
);

  cab_pkg::cab_cfg_t   cfg;
  cab_pkg::cab_stage_t st_data;
  cab_pkg::cab_out_t   res;
  cab_pkg::cab_out_t   out_data_r;
  logic                st_valid;
  logic                st_ready;
  logic                out_valid_r;

  assign cfg_ready = 1'b1;

  cab_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cab_walker #(
    .MAX_DIM (MAX_DIM)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_data  (st_data)
  );

  cab_compose u_compose (
    .st   (st_data),
    .mode (cfg.blend_mode),
    .res  (res)
  );

  assign st_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready) begin
      out_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      out_data_r <= res;
    end
  end

endmodule

// File: sim/clipped_alpha_blit_test.sv
// self-checking testbench for the clipped alpha blit: random placement, clipping and blending
`timescale 1ns / 1ps

module clipped_alpha_blit_test;

  localparam logic [cab_pkg::DIM_W-1:0] CFG_COPY  = cab_pkg::DIM_W'(cab_pkg::MODE_COPY);
  localparam logic [cab_pkg::DIM_W-1:0] CFG_KEY   = cab_pkg::DIM_W'(cab_pkg::MODE_KEY);
  localparam logic [cab_pkg::DIM_W-1:0] CFG_BLEND = cab_pkg::DIM_W'(cab_pkg::MODE_BLEND);
  localparam logic [cab_pkg::DIM_W-1:0] CFG_BLEND_ALT = 13'd3;
  localparam logic [cab_pkg::IDX_W-1:0] REG_UNUSED    = 3'd7;
  localparam int ITEM_TARGET = 1150;
  localparam int LONG_HOLD   = 200;
  localparam int IDLE_LIMIT  = 2000;

  class composite_tracker;
    logic signed [cab_pkg::DIM_W-1:0] place_col, place_row;
    logic [cab_pkg::DIM_W-1:0]        src_w, src_h, dst_w, dst_h;
    logic [cab_pkg::MODE_W-1:0]       mode;
    int                               col_cnt, row_cnt;
    cab_pkg::cab_out_t                expected_writes[$];
    int                               errors, checked, written, images_done;

    function new();
      place_col = '0;
      place_row = '0;
      src_w = '0;
      src_h = '0;
      dst_w = '0;
      dst_h = '0;
      mode = cab_pkg::MODE_COPY;
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function void write_reg(logic [cab_pkg::IDX_W-1:0] idx, logic [cab_pkg::DIM_W-1:0] v);
      case (idx)
        cab_pkg::REG_PLACE_COL:  place_col = v;
        cab_pkg::REG_PLACE_ROW:  place_row = v;
        cab_pkg::REG_SRC_WIDTH:  src_w = v;
        cab_pkg::REG_SRC_HEIGHT: src_h = v;
        cab_pkg::REG_DST_WIDTH:  dst_w = v;
        cab_pkg::REG_DST_HEIGHT: dst_h = v;
        cab_pkg::REG_BLEND_MODE: mode = v[cab_pkg::MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_dim(logic [cab_pkg::DIM_W-1:0] v);
      return (int'(v) > cab_pkg::MAX_DIM_DEF) ? cab_pkg::MAX_DIM_DEF : int'(v);
    endfunction

    function logic [7:0] mix(int s, int t, int a);
      int v;
      v = (s * a + t * (255 - a) + 254) / 255;
      return v[7:0];
    endfunction

    function logic [cab_pkg::PIX_W-1:0] blend(logic [cab_pkg::PIX_W-1:0] lo,
                                              logic [cab_pkg::PIX_W-1:0] up);
      logic [cab_pkg::PIX_W-1:0] r;
      int a;
      a = int'(up[31:24]);
      if (a == 255) return up;
      if (a == 0) return lo;
      for (int sh = 0; sh < cab_pkg::PIX_W; sh += 8) begin
        r[sh +: 8] = mix(int'(up[sh +: 8]), int'(lo[sh +: 8]), a);
      end
      return r;
    endfunction

    function void note_pixel(cab_pkg::cab_in_t d);
      cab_pkg::cab_out_t r;
      int sw, sh, dw, dh, tx, ty;
      bit row_end, img_end;
      r = '0;
      sw = clamp_dim(src_w);
      sh = clamp_dim(src_h);
      dw = clamp_dim(dst_w);
      dh = clamp_dim(dst_h);
      if (sw != 0 && sh != 0) begin
        tx = int'(place_col) + col_cnt;
        ty = int'(place_row) + row_cnt;
        row_end = (col_cnt + 1 >= sw);
        img_end = (row_cnt + 1 >= sh);
        r.last = row_end && img_end;
        if (tx >= 0 && ty >= 0 && tx < dw && ty < dh) begin
          case (mode)
            cab_pkg::MODE_COPY: begin
              r.write_enable = 1'b1;
              r.result_pixel = d.upper_pixel;
            end
            cab_pkg::MODE_KEY: begin
              r.write_enable = d.upper_pixel[cab_pkg::PIX_W-1];
              r.result_pixel = d.upper_pixel[cab_pkg::PIX_W-1] ? d.upper_pixel
                                                                : d.lower_pixel;
            end
            default: begin
              r.write_enable = 1'b1;
              r.result_pixel = blend(d.lower_pixel, d.upper_pixel);
            end
          endcase
          if (r.write_enable) begin
            r.target_col = tx[cab_pkg::COORD_W-1:0];
            r.target_row = ty[cab_pkg::COORD_W-1:0];
          end
        end
        if (row_end) begin
          col_cnt = 0;
          row_cnt = img_end ? 0 : row_cnt + 1;
        end else begin
          col_cnt = col_cnt + 1;
        end
      end else begin
        col_cnt = 0;
        row_cnt = 0;
      end
      expected_writes.push_back(r);
    endfunction

    function void check_write(cab_pkg::cab_out_t got);
      cab_pkg::cab_out_t e;
      if (expected_writes.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, got);
        errors++;
        return;
      end
      e = expected_writes.pop_front();
      checked++;
      if (e.write_enable) written++;
      if (e.last) images_done++;
      if (got !== e) begin
        $display("%0t: result mismatch, expected %b/%0d/%0d/%h/%b, got %b/%0d/%0d/%h/%b",
                 $time, e.write_enable, e.target_col, e.target_row, e.result_pixel, e.last,
                 got.write_enable, got.target_col, got.target_row, got.result_pixel,
                 got.last);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  cab_pkg::cab_in_t             in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  cab_pkg::cab_out_t            out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [cab_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [cab_pkg::DIM_W-1:0]    cfg_data = '0;

  composite_tracker sb = new();
  int  items_in = 0;
  int  idle_cycles = 0;
  int  holds_done = 0;
  bit  in_gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;

  clipped_alpha_blit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [cab_pkg::DIM_W-1:0] rand_reg_value(
      logic [cab_pkg::IDX_W-1:0] idx);
    int v;
    case (idx)
      cab_pkg::REG_PLACE_COL, cab_pkg::REG_PLACE_ROW: begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 8191);
        else v = int'($urandom_range(0, 12)) - 4;
      end
      cab_pkg::REG_SRC_WIDTH, cab_pkg::REG_SRC_HEIGHT: begin
        case ($urandom_range(0, 19))
          0, 1:    v = $urandom_range(0, 8191);
          2:       v = 0;
          default: v = $urandom_range(1, 6);
        endcase
      end
      cab_pkg::REG_DST_WIDTH, cab_pkg::REG_DST_HEIGHT: begin
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 8191);
        else v = $urandom_range(0, 8);
      end
      cab_pkg::REG_BLEND_MODE: v = $urandom_range(0, 8191);
      default: v = $urandom_range(0, 8191);
    endcase
    return v[cab_pkg::DIM_W-1:0];
  endfunction

  function automatic logic [cab_pkg::PIX_W-1:0] rand_upper();
    logic [cab_pkg::PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      2: p[31:24] = 8'($urandom_range(1, 3));
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(input logic [cab_pkg::PIX_W-1:0] up,
                            input logic [cab_pkg::PIX_W-1:0] lo);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{upper_pixel: up, lower_pixel: lo};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [cab_pkg::IDX_W-1:0] idx,
                           input logic [cab_pkg::DIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic setup(input logic [cab_pkg::DIM_W-1:0] pc, input logic [cab_pkg::DIM_W-1:0] pr,
                       input logic [cab_pkg::DIM_W-1:0] sw, input logic [cab_pkg::DIM_W-1:0] sh,
                       input logic [cab_pkg::DIM_W-1:0] dw, input logic [cab_pkg::DIM_W-1:0] dh,
                       input logic [cab_pkg::DIM_W-1:0] md);
    cfg_write(cab_pkg::REG_PLACE_COL, pc);
    cfg_write(cab_pkg::REG_PLACE_ROW, pr);
    cfg_write(cab_pkg::REG_SRC_WIDTH, sw);
    cfg_write(cab_pkg::REG_SRC_HEIGHT, sh);
    cfg_write(cab_pkg::REG_DST_WIDTH, dw);
    cfg_write(cab_pkg::REG_DST_HEIGHT, dh);
    cfg_write(cab_pkg::REG_BLEND_MODE, md);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_write(out_data);
      if (in_valid && in_ready) begin
        sb.note_pixel(in_data);
        items_in++;
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n, sw_eff, sh_eff, phase;
    bit pressure;
    logic [cab_pkg::IDX_W-1:0] idx;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty source straight after reset
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    drain_results();

    // copy with left and bottom clipping, image ends on the sixth item
    setup(-13'sd1, 13'd0, 13'd3, 13'd2, 13'd2, 13'd1, CFG_COPY);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'h1234_5678, 32'h9ABC_DEF0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'h8000_0001, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    drain_results();

    // keyed copy, key set and clear; unused register index ignored
    cfg_write(REG_UNUSED, 13'h1FFF);
    setup(13'd0, 13'd0, 13'd2, 13'd2, 13'd4, 13'd4, CFG_KEY);
    send_pixel(32'h8000_0000, 32'h1111_1111);
    send_pixel(32'h7FFF_FFFF, 32'hCAFE_F00D);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h00AB_CDEF, 32'hFFFF_FFFF);
    drain_results();

    // blend: opaque, transparent and partial alpha
    setup(13'd1, 13'd1, 13'd3, 13'd2, 13'd4096, 13'd4096, CFG_BLEND);
    send_pixel(32'hFF12_3456, 32'hFFFF_FFFF);
    send_pixel(32'h0012_3456, 32'h89AB_CDEF);
    send_pixel(32'h80FF_00FF, 32'h0000_FF00);
    send_pixel(32'h01FF_FFFF, 32'h0000_0000);
    send_pixel(32'hFE00_0000, 32'hFFFF_FFFF);
    send_pixel(32'h7F80_40C0, 32'h3366_99CC);
    drain_results();

    // unused mode code blends, tall narrow source
    setup(13'd0, 13'd0, 13'd1, 13'd3, 13'd1, 13'd1, CFG_BLEND_ALT);
    send_pixel(32'h4060_A0E0, 32'hC0FF_0010);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    drain_results();

    // oversize registers saturate, far corner of the target
    setup(13'd4095, 13'd4095, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, CFG_COPY);
    send_pixel(32'hDEAD_BEEF, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
    setup(13'h1000, 13'h1000, 13'd4, 13'd2, 13'd8, 13'd8, CFG_COPY);
    send_pixel(32'h0F0F_0F0F, 32'hF0F0_F0F0);
    drain_results();

    phase = 0;
    while (items_in < ITEM_TARGET) begin
      drain_results();
      if ($urandom_range(0, 3) == 0) begin
        // partial update, may shrink the source under a running image
        repeat ($urandom_range(1, 2)) begin
          idx = cab_pkg::IDX_W'($urandom_range(0, 7));
          cfg_write(idx, rand_reg_value(idx));
        end
        cfg_valid <= 1'b0;
      end else begin
        setup(rand_reg_value(cab_pkg::REG_PLACE_COL), rand_reg_value(cab_pkg::REG_PLACE_ROW),
              rand_reg_value(cab_pkg::REG_SRC_WIDTH), rand_reg_value(cab_pkg::REG_SRC_HEIGHT),
              rand_reg_value(cab_pkg::REG_DST_WIDTH), rand_reg_value(cab_pkg::REG_DST_HEIGHT),
              rand_reg_value(cab_pkg::REG_BLEND_MODE));
      end
      pressure = (phase % 6 == 2);
      in_gaps_on = ($urandom_range(0, 4) != 0) && !pressure;
      stall_on = ($urandom_range(0, 4) != 0);
      sw_eff = sb.clamp_dim(sb.src_w);
      sh_eff = sb.clamp_dim(sb.src_h);
      if (sw_eff == 0 || sh_eff == 0) n = $urandom_range(3, 8);
      else if (sw_eff * sh_eff <= 48)
        n = sw_eff * sh_eff * $urandom_range(1, 2) +
            (($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
      else n = $urandom_range(10, 40);
      if (pressure) begin
        if (n < 40) n = 40;
        hold_req = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        send_pixel(rand_upper(), $urandom);
        if (phase % 5 == 4 && i == n / 2) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d pixel items over %0d random setups, %0d results checked",
             items_in, phase, sb.checked);
    $display("%0d pixels written, %0d clipped or keyed out, %0d images finished, %0d long stalls",
             sb.written, sb.checked - sb.written, sb.images_done, holds_done);
    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
